[rtl/pmrt_pkg.sv]
// Shared types, constants and the arctangent table of the point transform.
package pmrt_pkg;

    localparam int unsigned XW = 33;   // CORDIC x / y width, Q30 signed
    localparam int unsigned ZW = 33;   // CORDIC angle width, Q24 degrees signed

    localparam logic [26:0] DEG90_Q16  = 27'd5898240;
    localparam logic [26:0] DEG180_Q16 = 27'd11796480;
    localparam logic [26:0] DEG270_Q16 = 27'd17694720;
    localparam logic [26:0] DEG360_Q16 = 27'd23592960;
    localparam logic [26:0] DEG720_Q16 = 27'd47185920;

    localparam logic signed [XW-1:0] GAIN_Q30 = 33'sd652032874;
    localparam logic signed [XW-1:0] ONE_Q30  = 33'sd1073741824;

    localparam logic signed [25:0] RST_MIN  = 26'sd0;
    localparam logic signed [25:0] RST_MAX  = 26'sd17694720;
    localparam logic [24:0]        RST_STEP = 25'd5898240;

    typedef enum logic [1:0] {
        REG_MIN  = 2'd0,
        REG_MAX  = 2'd1,
        REG_STEP = 2'd2,
        REG_NONE = 2'd3
    } t_reg_idx;

    // Fields that ride alongside the rotation unit
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               mirror;
        logic               ok;
        logic [1:0]         quad;
        logic               zero;
    } t_side;

    function automatic logic signed [ZW-1:0] atan_q24(input int unsigned i);
        logic signed [ZW-1:0] v;
        v = '0;
        unique case (i)
            0:  v = 33'sd754974720;
            1:  v = 33'sd445687602;
            2:  v = 33'sd235489088;
            3:  v = 33'sd119537938;
            4:  v = 33'sd60000934;
            5:  v = 33'sd30029717;
            6:  v = 33'sd15018523;
            7:  v = 33'sd7509720;
            8:  v = 33'sd3754917;
            9:  v = 33'sd1877466;
            10: v = 33'sd938734;
            11: v = 33'sd469367;
            12: v = 33'sd234684;
            13: v = 33'sd117342;
            14: v = 33'sd58671;
            15: v = 33'sd29335;
            16: v = 33'sd14668;
            17: v = 33'sd7334;
            18: v = 33'sd3667;
            19: v = 33'sd1833;
            20: v = 33'sd917;
            21: v = 33'sd458;
            22: v = 33'sd229;
            23: v = 33'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/pmrt_front.sv]
// Index check and angle reduction to quadrant plus remainder.
module pmrt_front
    import pmrt_pkg::*;
#(
    parameter int MAX_ROTATIONS = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic signed [25:0]   i_min,
    input  logic signed [25:0]   i_max,
    input  logic [24:0]          i_step,
    input  logic [15:0]          i_idx,
    input  t_side                i_side,
    output logic                 o_vld,
    output t_side                o_side,
    output logic signed [ZW-1:0] o_z
);
    localparam int MW = $clog2(MAX_ROTATIONS + 1);
    localparam int CW = MW + 25;
    localparam logic [MW-1:0] MAXM1 = MW'(MAX_ROTATIONS - 1);

    logic signed [26:0] w_span;
    logic [CW-1:0]      r_cap;
    logic               w_rng_ok;

    logic [4:0]         r_vld;
    t_side              r_side [5];
    t_side              w_side1, w_side4;
    logic [40:0]        r_prod;
    logic [26:0]        r_a2, r_a3, r_a4;
    logic [26:0]        w_ang;
    logic               w_ok;
    logic [26:0]        w_r;
    logic [1:0]         w_q;
    logic signed [ZW-1:0] r_z;

    assign w_span = 27'(i_max) - 27'(i_min);

    // Set-size cap depends on configuration only; refresh every cycle
    always_ff @(posedge i_clk) begin
        r_cap <= MAXM1 * i_step;
    end

    assign w_rng_ok = (i_step != '0) && !w_span[26] && (CW'(w_span[25:0]) <= r_cap);

    assign w_ok  = w_rng_ok && (r_prod <= 41'(w_span[25:0])) && !w_span[26];
    assign w_ang = 27'(i_min) + r_prod[26:0] + DEG720_Q16;

    always_comb begin
        priority if (r_a4 >= DEG270_Q16) begin
            w_q = 2'd3; w_r = r_a4 - DEG270_Q16;
        end else if (r_a4 >= DEG180_Q16) begin
            w_q = 2'd2; w_r = r_a4 - DEG180_Q16;
        end else if (r_a4 >= DEG90_Q16) begin
            w_q = 2'd1; w_r = r_a4 - DEG90_Q16;
        end else begin
            w_q = 2'd0; w_r = r_a4;
        end
    end

    always_comb begin
        w_side1      = r_side[0];
        w_side1.ok   = w_ok;
        w_side4      = r_side[3];
        w_side4.quad = w_q;
        w_side4.zero = (w_r == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
        if (i_en) begin
            // product stage
            r_prod    <= i_idx * i_step;
            r_side[0] <= i_side;
            // check and offset into a non-negative range
            r_a2      <= w_ang;
            r_side[1] <= w_side1;
            // fold by two turns, then by one
            r_a3      <= (r_a2 >= DEG720_Q16) ? r_a2 - DEG720_Q16 : r_a2;
            r_side[2] <= r_side[1];
            r_a4      <= (r_a3 >= DEG360_Q16) ? r_a3 - DEG360_Q16 : r_a3;
            r_side[3] <= r_side[2];
            // split into quadrant and remainder
            r_z       <= ZW'({w_r[22:0], 8'd0});
            r_side[4] <= w_side4;
        end
    end

    assign o_vld  = r_vld[4];
    assign o_side = r_side[4];
    assign o_z    = r_z;
endmodule

[rtl/pmrt_cell.sv]
// One CORDIC rotation cell with its registered sideband.
module pmrt_cell
    import pmrt_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  t_side                i_side,
    output logic                 o_vld,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output t_side                o_side
);
    localparam logic signed [ZW-1:0] ATAN = atan_q24(STAGE);

    logic signed [XW-1:0] w_dx, w_dy;

    assign w_dx = i_y >>> STAGE;
    assign w_dy = i_x >>> STAGE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
        if (i_en) begin
            if (!i_z[ZW-1]) begin
                o_x <= i_x - w_dx;
                o_y <= i_y + w_dy;
                o_z <= i_z - ATAN;
            end else begin
                o_x <= i_x + w_dx;
                o_y <= i_y - w_dy;
                o_z <= i_z + ATAN;
            end
            o_side <= i_side;
        end
    end
endmodule

[rtl/pmrt_back.sv]
// Quadrant fix-up, mirror, rotation products, translation and saturation.
module pmrt_back
    import pmrt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic signed [XW-1:0] i_c,
    input  logic signed [XW-1:0] i_s,
    input  t_side                i_side,
    output logic                 o_vld,
    output logic [31:0]          o_x,
    output logic [31:0]          o_y,
    output logic                 o_ok
);
    logic [3:0]           r_vld;
    logic signed [XW-1:0] w_c, w_s, r_cq, r_sq, r_px, r_py;
    logic signed [65:0]   r_pxc, r_pys, r_pxs, r_pyc;
    logic signed [66:0]   w_sx, w_sy;
    logic signed [33:0]   r_rx, r_ry;
    logic signed [34:0]   w_tx, w_ty;
    t_side                r_side [3];

    assign w_c = i_side.zero ? ONE_Q30 : i_c;
    assign w_s = i_side.zero ? '0      : i_s;

    assign w_sx = 67'(r_pxc) - 67'(r_pys) + 67'sd536870912;
    assign w_sy = 67'(r_pxs) + 67'(r_pyc) + 67'sd536870912;
    assign w_tx = 35'(r_rx) + 35'(r_side[2].sx);
    assign w_ty = 35'(r_ry) + 35'(r_side[2].sy);

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] res;
        if (v > 35'sd2147483647) res = 32'h7FFF_FFFF;
        else if (v < -35'sd2147483648) res = 32'h8000_0000;
        else res = v[31:0];
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
        if (i_en) begin
            unique case (i_side.quad)
                2'd0: begin r_cq <= w_c;  r_sq <= w_s;  end
                2'd1: begin r_cq <= -w_s; r_sq <= w_c;  end
                2'd2: begin r_cq <= -w_c; r_sq <= -w_s; end
                default: begin r_cq <= w_s; r_sq <= -w_c; end
            endcase
            r_px      <= i_side.mirror ? -XW'(i_side.px) : XW'(i_side.px);
            r_py      <= XW'(i_side.py);
            r_side[0] <= i_side;
            r_pxc     <= r_px * r_cq;
            r_pys     <= r_py * r_sq;
            r_pxs     <= r_px * r_sq;
            r_pyc     <= r_py * r_cq;
            r_side[1] <= r_side[0];
            r_rx      <= w_sx[63:30];
            r_ry      <= w_sy[63:30];
            r_side[2] <= r_side[1];
            o_x       <= r_side[2].ok ? sat32(w_tx) : '0;
            o_y       <= r_side[2].ok ? sat32(w_ty) : '0;
            o_ok      <= r_side[2].ok;
        end
    end

    assign o_vld = r_vld[3];
endmodule

[rtl/point_mirror_rotate_translate.sv]
// Mirror, rotate by an indexed angle, translate and saturate a Q16.16 point.
// Throughput: one beat per cycle while the output is not stalled; every
// stage is a register and the chain of CORDIC cells hands one rotation
// step to its neighbor each cycle.
// The whole pipeline holds while the output beat waits to be taken.
// Reset (synchronous, active low) clears valid bits and restores the range
// registers to min 0, max 270 degrees, step 90 degrees.
module point_mirror_rotate_translate
    import pmrt_pkg::*;
#(
    parameter int MAX_ROTATIONS = 65536,
    parameter int CORDIC_STAGES = 18
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input stream
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // tdata: point_x[31:0], point_y[63:32], rot_index[79:64],
    //        shift_x[111:80], shift_y[143:112]
    input  logic [143:0]  i_s_axis_tdata,
    // tuser: mirror_flag[0]
    input  logic          i_s_axis_tuser,
    // output stream
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // tdata: out_x[31:0], out_y[63:32]
    output logic [63:0]   o_m_axis_tdata,
    // tuser: result_ok[0]
    output logic          o_m_axis_tuser,
    // configuration writes
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_addr,
    input  logic [25:0]   i_cfg_data
);
    localparam int NS = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

    logic signed [25:0] r_min, r_max;
    logic [24:0]        r_step;
    logic               w_en;
    t_side              w_in_side;
    logic               w_acc;
    logic               w_out_vld;

    // cell chain taps
    logic                 c_vld  [NS+1];
    logic signed [XW-1:0] c_x    [NS+1];
    logic signed [XW-1:0] c_y    [NS+1];
    logic signed [ZW-1:0] c_z    [NS+1];
    t_side                c_side [NS+1];

    // Take no configuration beat while reset holds the registers
    assign o_cfg_ready = i_rst_n;

    // Configuration registers; writes to an unknown index drop silently
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= RST_MIN;
            r_max  <= RST_MAX;
            r_step <= RST_STEP;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_MIN:  r_min  <= i_cfg_data;
                REG_MAX:  r_max  <= i_cfg_data;
                REG_STEP: r_step <= i_cfg_data[24:0];
                default: ;
            endcase
        end
    end

    // Advance everything unless the output beat is stuck; take no input
    // beat during reset
    assign w_en            = !w_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en && i_rst_n;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        w_in_side        = '0;
        w_in_side.px     = i_s_axis_tdata[31:0];
        w_in_side.py     = i_s_axis_tdata[63:32];
        w_in_side.sx     = i_s_axis_tdata[111:80];
        w_in_side.sy     = i_s_axis_tdata[143:112];
        w_in_side.mirror = i_s_axis_tuser;
    end

    pmrt_front #(
        .MAX_ROTATIONS(MAX_ROTATIONS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_acc),
        .i_min   (r_min),
        .i_max   (r_max),
        .i_step  (r_step),
        .i_idx   (i_s_axis_tdata[79:64]),
        .i_side  (w_in_side),
        .o_vld   (c_vld[0]),
        .o_side  (c_side[0]),
        .o_z     (c_z[0])
    );

    // Seed the rotation at the gain-compensated unit vector
    assign c_x[0] = GAIN_Q30;
    assign c_y[0] = '0;

    for (genvar g = 0; g < NS; g++) begin : g_cell
        pmrt_cell #(
            .STAGE(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (c_vld[g]),
            .i_x     (c_x[g]),
            .i_y     (c_y[g]),
            .i_z     (c_z[g]),
            .i_side  (c_side[g]),
            .o_vld   (c_vld[g+1]),
            .o_x     (c_x[g+1]),
            .o_y     (c_y[g+1]),
            .o_z     (c_z[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    pmrt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (c_vld[NS]),
        .i_c     (c_x[NS]),
        .i_s     (c_y[NS]),
        .i_side  (c_side[NS]),
        .o_vld   (w_out_vld),
        .o_x     (o_m_axis_tdata[31:0]),
        .o_y     (o_m_axis_tdata[63:32]),
        .o_ok    (o_m_axis_tuser)
    );

    assign o_m_axis_tvalid = w_out_vld;
endmodule
